>>> sv/tps_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the pattern table of the tone pattern sequencer.
// No dependencies; every other file of the block refers to this package.
package tps_pkg;

  localparam int PatternCount = 16;
  localparam int MaxTones     = 19;
  localparam int FreqW        = 11;
  localparam int DurW         = 9;
  localparam int VolW         = 8;
  localparam int PatW         = 4;
  localparam int IdxW         = 5;
  localparam int CodeW        = 5;
  localparam int ModeW        = 2;

  localparam logic [ModeW-1:0] ModeTick = 2'd0;
  localparam logic [ModeW-1:0] ModePlay = 2'd1;
  localparam logic [ModeW-1:0] ModeStop = 2'd2;

  localparam logic [CodeW-1:0] BlinkCode   = 5'd16;
  localparam logic [DurW-1:0]  ElapsedMax  = '1;
  localparam logic [VolW-1:0]  VolumeReset = 8'd128;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [DurW-1:0]  dur;
  } tone_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CodeW-1:0] emotion;
  } item_t;

  typedef struct packed {
    logic [FreqW-1:0] tone_freq;
    logic [VolW-1:0]  duty;
    logic             sounding;
    logic             busy_res;
    logic             finished;
  } result_t;

  function automatic tone_t mk(input int f, input int d);
    tone_t t;
    t.freq = FreqW'(f);
    t.dur  = DurW'(d);
    return t;
  endfunction

  // Number of tones in each pattern, cut to the longest pattern allowed.
  function automatic logic [IdxW-1:0] eff_len(input logic [PatW-1:0] pat);
    logic [IdxW-1:0] n;
    case (pat)
      4'd0:    n = 5'd1;
      4'd1:    n = 5'd5;
      4'd2:    n = 5'd5;
      4'd3:    n = 5'd9;
      4'd4:    n = 5'd5;
      4'd5:    n = 5'd19;
      4'd6:    n = 5'd7;
      4'd7:    n = 5'd5;
      4'd8:    n = 5'd7;
      4'd9:    n = 5'd7;
      4'd10:   n = 5'd7;
      4'd11:   n = 5'd3;
      4'd12:   n = 5'd7;
      4'd13:   n = 5'd3;
      4'd14:   n = 5'd7;
      default: n = 5'd3;
    endcase
    if (n > IdxW'(MaxTones)) n = IdxW'(MaxTones);
    return n;
  endfunction

  // Frequency and duration of one step; steps past a pattern's end read as zero.
  function automatic tone_t tone_at(input logic [PatW-1:0] pat, input logic [IdxW-1:0] idx);
    tone_t t;
    case ({pat, idx})
      {4'd0, 5'd0}:   t = mk(800, 150);
      {4'd1, 5'd0}:   t = mk(600, 60);
      {4'd1, 5'd1}:   t = mk(0, 30);
      {4'd1, 5'd2}:   t = mk(900, 60);
      {4'd1, 5'd3}:   t = mk(0, 30);
      {4'd1, 5'd4}:   t = mk(1200, 100);
      {4'd2, 5'd0}:   t = mk(700, 200);
      {4'd2, 5'd1}:   t = mk(0, 100);
      {4'd2, 5'd2}:   t = mk(500, 250);
      {4'd2, 5'd3}:   t = mk(0, 100);
      {4'd2, 5'd4}:   t = mk(300, 300);
      {4'd3, 5'd0}:   t = mk(1400, 40);
      {4'd3, 5'd1}:   t = mk(0, 40);
      {4'd3, 5'd2}:   t = mk(1400, 40);
      {4'd3, 5'd3}:   t = mk(0, 40);
      {4'd3, 5'd4}:   t = mk(1400, 40);
      {4'd3, 5'd5}:   t = mk(0, 40);
      {4'd3, 5'd6}:   t = mk(1400, 40);
      {4'd3, 5'd7}:   t = mk(0, 40);
      {4'd3, 5'd8}:   t = mk(1600, 120);
      {4'd4, 5'd0}:   t = mk(600, 180);
      {4'd4, 5'd1}:   t = mk(0, 80);
      {4'd4, 5'd2}:   t = mk(450, 200);
      {4'd4, 5'd3}:   t = mk(0, 80);
      {4'd4, 5'd4}:   t = mk(350, 250);
      {4'd5, 5'd0}:   t = mk(1800, 50);
      {4'd5, 5'd1}:   t = mk(0, 30);
      {4'd5, 5'd2}:   t = mk(1600, 50);
      {4'd5, 5'd3}:   t = mk(0, 30);
      {4'd5, 5'd4}:   t = mk(1800, 50);
      {4'd5, 5'd5}:   t = mk(0, 30);
      {4'd5, 5'd6}:   t = mk(1600, 50);
      {4'd5, 5'd7}:   t = mk(0, 30);
      {4'd5, 5'd8}:   t = mk(1800, 50);
      {4'd5, 5'd9}:   t = mk(0, 30);
      {4'd5, 5'd10}:  t = mk(1600, 50);
      {4'd5, 5'd11}:  t = mk(0, 30);
      {4'd5, 5'd12}:  t = mk(1800, 50);
      {4'd5, 5'd13}:  t = mk(0, 30);
      {4'd5, 5'd14}:  t = mk(1600, 50);
      {4'd5, 5'd15}:  t = mk(0, 30);
      {4'd5, 5'd16}:  t = mk(1800, 50);
      {4'd5, 5'd17}:  t = mk(0, 30);
      {4'd5, 5'd18}:  t = mk(1600, 50);
      {4'd6, 5'd0}:   t = mk(700, 100);
      {4'd6, 5'd1}:   t = mk(0, 50);
      {4'd6, 5'd2}:   t = mk(900, 80);
      {4'd6, 5'd3}:   t = mk(0, 50);
      {4'd6, 5'd4}:   t = mk(600, 100);
      {4'd6, 5'd5}:   t = mk(0, 50);
      {4'd6, 5'd6}:   t = mk(800, 80);
      {4'd7, 5'd0}:   t = mk(1000, 100);
      {4'd7, 5'd1}:   t = mk(0, 150);
      {4'd7, 5'd2}:   t = mk(1000, 100);
      {4'd7, 5'd3}:   t = mk(0, 150);
      {4'd7, 5'd4}:   t = mk(1000, 100);
      {4'd8, 5'd0}:   t = mk(880, 120);
      {4'd8, 5'd1}:   t = mk(0, 50);
      {4'd8, 5'd2}:   t = mk(1047, 120);
      {4'd8, 5'd3}:   t = mk(0, 50);
      {4'd8, 5'd4}:   t = mk(1319, 200);
      {4'd8, 5'd5}:   t = mk(0, 50);
      {4'd8, 5'd6}:   t = mk(1047, 150);
      {4'd9, 5'd0}:   t = mk(400, 50);
      {4'd9, 5'd1}:   t = mk(0, 20);
      {4'd9, 5'd2}:   t = mk(800, 50);
      {4'd9, 5'd3}:   t = mk(0, 20);
      {4'd9, 5'd4}:   t = mk(1400, 50);
      {4'd9, 5'd5}:   t = mk(0, 20);
      {4'd9, 5'd6}:   t = mk(1800, 120);
      {4'd10, 5'd0}:  t = mk(800, 150);
      {4'd10, 5'd1}:  t = mk(0, 50);
      {4'd10, 5'd2}:  t = mk(600, 150);
      {4'd10, 5'd3}:  t = mk(0, 50);
      {4'd10, 5'd4}:  t = mk(400, 150);
      {4'd10, 5'd5}:  t = mk(0, 50);
      {4'd10, 5'd6}:  t = mk(200, 300);
      {4'd11, 5'd0}:  t = mk(400, 300);
      {4'd11, 5'd1}:  t = mk(0, 200);
      {4'd11, 5'd2}:  t = mk(300, 400);
      {4'd12, 5'd0}:  t = mk(700, 150);
      {4'd12, 5'd1}:  t = mk(0, 80);
      {4'd12, 5'd2}:  t = mk(900, 180);
      {4'd12, 5'd3}:  t = mk(0, 100);
      {4'd12, 5'd4}:  t = mk(700, 150);
      {4'd12, 5'd5}:  t = mk(0, 80);
      {4'd12, 5'd6}:  t = mk(900, 220);
      {4'd13, 5'd0}:  t = mk(440, 200);
      {4'd13, 5'd1}:  t = mk(0, 150);
      {4'd13, 5'd2}:  t = mk(460, 250);
      {4'd14, 5'd0}:  t = mk(900, 70);
      {4'd14, 5'd1}:  t = mk(0, 30);
      {4'd14, 5'd2}:  t = mk(1100, 70);
      {4'd14, 5'd3}:  t = mk(0, 30);
      {4'd14, 5'd4}:  t = mk(900, 70);
      {4'd14, 5'd5}:  t = mk(0, 30);
      {4'd14, 5'd6}:  t = mk(1200, 120);
      {4'd15, 5'd0}:  t = mk(320, 200);
      {4'd15, 5'd1}:  t = mk(0, 60);
      {4'd15, 5'd2}:  t = mk(260, 280);
      default:        t = mk(0, 0);
    endcase
    return t;
  endfunction

endpackage

>>> sv/tps_in_if.sv
`timescale 1ns / 1ps
// Input channel of the tone pattern sequencer: valid/ready plus request word.
// Depends on tps_pkg for field widths.
interface tps_in_if;
  logic                      valid;
  logic                      ready;
  logic [tps_pkg::ModeW-1:0] mode;
  logic [tps_pkg::CodeW-1:0] emotion;

  modport source (output valid, mode, emotion, input ready);
  modport sink   (input valid, mode, emotion, output ready);
endinterface

>>> sv/tps_out_if.sv
`timescale 1ns / 1ps
// Output channel of the tone pattern sequencer: valid/ready plus status word.
// Depends on tps_pkg for field widths.
interface tps_out_if;
  logic                      valid;
  logic                      ready;
  logic [tps_pkg::FreqW-1:0] tone_freq;
  logic [tps_pkg::VolW-1:0]  duty;
  logic                      sounding;
  logic                      busy_res;
  logic                      finished;

  modport source (output valid, tone_freq, duty, sounding, busy_res, finished, input ready);
  modport sink   (input valid, tone_freq, duty, sounding, busy_res, finished, output ready);
endinterface

>>> sv/tps_seq_core.sv
`timescale 1ns / 1ps
// Player state and its combinational update for one request word.
// Depends on tps_pkg for the pattern table, codes and structs.
module tps_seq_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  tps_pkg::item_t           item_i,
  input  logic [tps_pkg::VolW-1:0] volume_i,
  output tps_pkg::result_t         res_o
);

  logic                     active_q, active_d;
  logic [tps_pkg::PatW-1:0] pat_q, pat_d;
  logic [tps_pkg::IdxW-1:0] idx_q, idx_d;
  logic [tps_pkg::DurW-1:0] el_q, el_d;
  logic                     tone_on_q, tone_on_d;

  logic [tps_pkg::DurW-1:0] el_inc;
  logic [tps_pkg::IdxW-1:0] idx_inc;
  logic [tps_pkg::PatW-1:0] play_pat;
  tps_pkg::tone_t           cur_tone, nxt_tone, first_tone, shown_tone;
  logic                     fin;
  logic                     snd;

  always_comb begin
    active_d  = active_q;
    pat_d     = pat_q;
    idx_d     = idx_q;
    el_d      = el_q;
    tone_on_d = tone_on_q;
    fin       = 1'b0;

    cur_tone   = tps_pkg::tone_at(pat_q, idx_q);
    idx_inc    = idx_q + 5'd1;
    nxt_tone   = tps_pkg::tone_at(pat_q, idx_inc);
    el_inc     = (el_q != tps_pkg::ElapsedMax) ? el_q + 9'd1 : el_q;
    // codes without a pattern fall back to the idle pattern
    play_pat   = (item_i.emotion < tps_pkg::CodeW'(tps_pkg::PatternCount))
                 ? item_i.emotion[tps_pkg::PatW-1:0] : '0;
    first_tone = tps_pkg::tone_at(play_pat, '0);

    if (step_i) begin
      case (item_i.mode)
        tps_pkg::ModeTick: begin
          if (active_q) begin
            el_d = el_inc;
            if (el_inc >= cur_tone.dur) begin
              idx_d = idx_inc;
              el_d  = '0;
              if (idx_inc >= tps_pkg::eff_len(pat_q)) begin
                active_d  = 1'b0;
                pat_d     = '0;
                idx_d     = '0;
                tone_on_d = 1'b0;
                fin       = 1'b1;
              end else begin
                tone_on_d = (nxt_tone.freq != '0);
              end
            end
          end
        end
        tps_pkg::ModePlay: begin
          // drop a request while busy, and the blink code altogether
          if (!active_q && item_i.emotion != tps_pkg::BlinkCode) begin
            pat_d     = play_pat;
            idx_d     = '0;
            el_d      = '0;
            active_d  = 1'b1;
            tone_on_d = (first_tone.freq != '0);
          end
        end
        tps_pkg::ModeStop: begin
          fin       = active_q;
          active_d  = 1'b0;
          pat_d     = '0;
          idx_d     = '0;
          el_d      = '0;
          tone_on_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    shown_tone      = tps_pkg::tone_at(pat_d, idx_d);
    snd             = active_d && tone_on_d;
    res_o.tone_freq = snd ? shown_tone.freq : '0;
    res_o.duty      = snd ? volume_i : '0;
    res_o.sounding  = snd;
    res_o.busy_res  = active_d;
    res_o.finished  = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      pat_q     <= '0;
      idx_q     <= '0;
      el_q      <= '0;
      tone_on_q <= 1'b0;
    end else if (step_i) begin
      active_q  <= active_d;
      pat_q     <= pat_d;
      idx_q     <= idx_d;
      el_q      <= el_d;
      tone_on_q <= tone_on_d;
    end
  end

endmodule

>>> sv/tone_pattern_sequencer.sv
`timescale 1ns / 1ps
// Top level of the tone pattern sequencer: input register, player core, result register.
// Depends on tps_pkg, tps_in_if, tps_out_if and tps_seq_core.

// Buzzer tone pattern player. Each input word is a 1 ms tick, a play request or a
// stop request, and each one yields exactly one status word (frequency, duty,
// sounding, busy, finished). One word is taken per clock cycle while ready is high.
// A word waits in the input register until the result register is empty or being
// drained; then the player update, a single pass through the pattern table, loads
// its status word into the result register, which drives the output. ready is high
// while the input register is empty or the result register is empty or being drained.
// The volume register may be written only while no word is in flight; its new value
// shows on duty from the next word on.
module tone_pattern_sequencer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tps_in_if.sink                   in_i,
  tps_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [tps_pkg::VolW-1:0] cfg_wdata_i
);

  logic                     s1_valid_q;
  tps_pkg::item_t           s1_item_q;
  logic                     s1_go;
  logic                     out_valid_q;
  tps_pkg::result_t         out_res_q;
  tps_pkg::result_t         core_res;
  logic [tps_pkg::VolW-1:0] volume_q;
  logic                     in_fire;

  // advance the staged word whenever the result slot is free or draining
  assign s1_go     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= tps_pkg::VolumeReset;
    end else if (cfg_we_i) begin
      volume_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.mode    <= in_i.mode;
      s1_item_q.emotion <= in_i.emotion;
    end
  end

  tps_seq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_go),
    .item_i   (s1_item_q),
    .volume_i (volume_q),
    .res_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.tone_freq = out_res_q.tone_freq;
  assign out_o.duty      = out_res_q.duty;
  assign out_o.sounding  = out_res_q.sounding;
  assign out_o.busy_res  = out_res_q.busy_res;
  assign out_o.finished  = out_res_q.finished;

`ifndef SYNTHESIS
  a_fin_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.finished |-> !out_res_q.busy_res)
    else $error("finished reported while still busy");

  a_sound_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.sounding |->
      out_res_q.busy_res && (out_res_q.tone_freq != '0) && (out_res_q.duty == volume_q))
    else $error("sounding word with bad frequency, duty or busy");

  a_silent_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.sounding |->
      (out_res_q.tone_freq == '0) && (out_res_q.duty == '0))
    else $error("silent word carries frequency or duty");

  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && !in_fire |=> !s1_valid_q)
    else $error("staged word not released after advance");
`endif

endmodule

>>> bench/tone_pattern_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tone_pattern_sequencer: a directed table, then random play sessions.
// Needs tps_pkg, tps_in_if, tps_out_if and the block's RTL; holds its own copy of the tone table.
module tone_pattern_sequencer_tb;
  import tps_pkg::*;

  localparam logic [ModeW-1:0] ModeNone      = 2'd3;
  localparam logic [CodeW-1:0] NoPatternCode = 5'd31;
  localparam int               LimitCycles   = 400000;
  localparam int               DrainCycles   = 4;
  localparam int               MaxErrLines   = 40;

  typedef enum logic {RowWord, RowVolume} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [ModeW-1:0] mode;
    logic [CodeW-1:0] code;
    int               reps;
    bit               typed;
    result_t          want;
    logic [VolW-1:0]  vol;
  } row_t;

  typedef struct {
    bit      typed;
    result_t want;
  } word_tag_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [VolW-1:0] cfg_wdata;

  tps_in_if  in_if ();
  tps_out_if out_if ();

  tone_pattern_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Tones of all patterns back to back as (hz, ms) pairs; song_len gives each pattern's count.
  int unsigned song_len [PatternCount] = '{1, 5, 5, 9, 5, 19, 7, 5, 7, 7, 7, 3, 7, 3, 7, 3};
  int unsigned song_steps [200] = '{
    800,150,
    600,60, 0,30, 900,60, 0,30, 1200,100,
    700,200, 0,100, 500,250, 0,100, 300,300,
    1400,40, 0,40, 1400,40, 0,40, 1400,40, 0,40, 1400,40, 0,40, 1600,120,
    600,180, 0,80, 450,200, 0,80, 350,250,
    1800,50, 0,30, 1600,50, 0,30, 1800,50, 0,30, 1600,50, 0,30,
    1800,50, 0,30, 1600,50, 0,30, 1800,50, 0,30, 1600,50, 0,30,
    1800,50, 0,30, 1600,50,
    700,100, 0,50, 900,80, 0,50, 600,100, 0,50, 800,80,
    1000,100, 0,150, 1000,100, 0,150, 1000,100,
    880,120, 0,50, 1047,120, 0,50, 1319,200, 0,50, 1047,150,
    400,50, 0,20, 800,50, 0,20, 1400,50, 0,20, 1800,120,
    800,150, 0,50, 600,150, 0,50, 400,150, 0,50, 200,300,
    400,300, 0,200, 300,400,
    700,150, 0,80, 900,180, 0,100, 700,150, 0,80, 900,220,
    440,200, 0,150, 460,250,
    900,70, 0,30, 1100,70, 0,30, 900,70, 0,30, 1200,120,
    320,200, 0,60, 260,280
  };

  // Player state as predicted
  bit               pl_active;
  logic [PatW-1:0]  pl_sel;
  logic [IdxW-1:0]  pl_idx;
  logic [DurW-1:0]  pl_ms;
  bit               pl_tone_on;
  logic [VolW-1:0]  pl_volume;

  result_t   status_q [$];
  word_tag_t tag_q [$];
  row_t      plan [$];

  int src_idle_pct = 30;
  int snk_idle_pct = 51;
  int err_cnt      = 0;
  int words_sent   = 0;
  int words_seen   = 0;
  int pat_ended    = 0;
  int vol_writes   = 0;
  int cycle_cnt    = 0;

  function automatic int unsigned step_pos(input logic [PatW-1:0] p, input logic [IdxW-1:0] i);
    int unsigned base;
    base = 0;
    for (int q = 0; q < int'(p); q++) base += song_len[q];
    return 2 * (base + i);
  endfunction

  function automatic logic [FreqW-1:0] step_hz(input logic [PatW-1:0] p,
                                               input logic [IdxW-1:0] i);
    return FreqW'(song_steps[step_pos(p, i)]);
  endfunction

  function automatic int unsigned step_ms(input logic [PatW-1:0] p, input logic [IdxW-1:0] i);
    return song_steps[step_pos(p, i) + 1];
  endfunction

  function automatic result_t status(input int hz, input int d, input bit snd,
                                     input bit busy, input bit fin);
    return {FreqW'(hz), VolW'(d), snd, busy, fin};
  endfunction

  task automatic go_quiet();
    pl_active  = 1'b0;
    pl_sel     = '0;
    pl_idx     = '0;
    pl_ms      = '0;
    pl_tone_on = 1'b0;
  endtask

  // Advance the player by one request word and return the status it reports.
  task automatic play_step(input logic [ModeW-1:0] m, input logic [CodeW-1:0] c,
                           output result_t r);
    bit fin;
    bit snd;
    fin = 1'b0;
    case (m)
      ModeTick: begin
        if (pl_active) begin
          if (pl_ms != ElapsedMax) pl_ms = pl_ms + 1'b1;
          if (int'(pl_ms) >= step_ms(pl_sel, pl_idx)) begin
            pl_idx = pl_idx + 1'b1;
            pl_ms  = '0;
            if (int'(pl_idx) >= song_len[pl_sel]) begin
              go_quiet();
              fin = 1'b1;
            end else begin
              pl_tone_on = step_hz(pl_sel, pl_idx) != 0;
            end
          end
        end
      end
      ModePlay: begin
        if (!pl_active && c != BlinkCode) begin
          pl_sel     = (c < PatternCount) ? PatW'(c) : '0;
          pl_idx     = '0;
          pl_ms      = '0;
          pl_active  = 1'b1;
          pl_tone_on = step_hz(pl_sel, '0) != 0;
        end
      end
      ModeStop: begin
        fin = pl_active;
        go_quiet();
      end
      default: ;
    endcase
    snd = pl_active && pl_tone_on;
    r = status(snd ? int'(step_hz(pl_sel, pl_idx)) : 0, snd ? int'(pl_volume) : 0,
               snd, pl_active, fin);
  endtask

  function automatic void field_check(input string name, input int unsigned e,
                                      input int unsigned a);
    if (e != a) begin
      err_cnt++;
      if (err_cnt <= MaxErrLines)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
    end
  endfunction

  // Check the status words and predict each accepted request word
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    word_tag_t tag;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.tone_freq, out_if.duty, out_if.sounding, out_if.busy_res,
               out_if.finished};
        words_seen++;
        if (got.finished) pat_ended++;
        if (status_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxErrLines)
            $display("%0t: status word with nothing expected, got %h", $time, got);
        end else begin
          want = status_q.pop_front();
          field_check("tone_freq", want.tone_freq, got.tone_freq);
          field_check("duty", want.duty, got.duty);
          field_check("sounding", want.sounding, got.sounding);
          field_check("busy_res", want.busy_res, got.busy_res);
          field_check("finished", want.finished, got.finished);
        end
      end
      if (in_if.valid && in_if.ready) begin
        play_step(in_if.mode, in_if.emotion, want);
        tag = tag_q.pop_front();
        status_q.push_back(tag.typed ? tag.want : want);
      end
    end
  end

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("Timeout after %0d cycles", LimitCycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_word(input logic [ModeW-1:0] m, input logic [CodeW-1:0] c,
                           input bit typed, input result_t want);
    word_tag_t tag;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tag.typed = typed;
    tag.want  = want;
    tag_q.push_back(tag);
    in_if.valid   <= 1'b1;
    in_if.mode    <= m;
    in_if.emotion <= c;
    words_sent++;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_volume(input logic [VolW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    pl_volume = v;
    vol_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic add_word(input logic [ModeW-1:0] m, input logic [CodeW-1:0] c, input int n);
    row_t r;
    r.kind  = RowWord;
    r.mode  = m;
    r.code  = c;
    r.reps  = n;
    r.typed = 1'b0;
    r.want  = '0;
    r.vol   = '0;
    plan.push_back(r);
  endtask

  task automatic add_typed(input logic [ModeW-1:0] m, input logic [CodeW-1:0] c,
                           input result_t want);
    add_word(m, c, 1);
    plan[$].typed = 1'b1;
    plan[$].want  = want;
  endtask

  task automatic add_volume(input logic [VolW-1:0] v);
    add_word(ModeNone, '0, 0);
    plan[$].kind = RowVolume;
    plan[$].vol  = v;
  endtask

  // Play sessions: a request, then mostly ticks with some noise; a few run clean long
  // enough for the idle pattern to end on its own.
  task automatic random_session(input int budget);
    int start;
    int n;
    int r;
    bit clean;
    logic [CodeW-1:0] c;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(5) == 0) begin
        drain();
        write_volume(VolW'($urandom_range(255)));
      end
      r = $urandom_range(99);
      if (r < 80)      c = CodeW'($urandom_range(PatternCount - 1));
      else if (r < 90) c = BlinkCode;
      else             c = CodeW'($urandom_range(31, 17));
      push_word(ModePlay, c, 1'b0, '0);
      clean = ($urandom_range(11) == 0);
      n = clean ? 160 : $urandom_range(1, 60);
      repeat (n) begin
        r = clean ? 0 : $urandom_range(99);
        c = CodeW'($urandom_range(31));
        if (r < 90)      push_word(ModeTick, c, 1'b0, '0);
        else if (r < 93) push_word(ModePlay, c, 1'b0, '0);
        else if (r < 96) push_word(ModeNone, c, 1'b0, '0);
        else begin
          push_word(ModeStop, c, 1'b0, '0);
          break;
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.mode    = ModeTick;
    in_if.emotion = '0;
    out_if.ready  = 1'b0;
    pl_volume     = VolumeReset;
    go_quiet();

    add_typed(ModeTick, '0, status(0, 0, 0, 0, 0));
    add_typed(ModeStop, '0, status(0, 0, 0, 0, 0));
    add_typed(ModeNone, '0, status(0, 0, 0, 0, 0));
    add_typed(ModePlay, BlinkCode, status(0, 0, 0, 0, 0));
    add_typed(ModePlay, 5'd0, status(800, 128, 1, 1, 0));
    add_typed(ModePlay, 5'd5, status(800, 128, 1, 1, 0));     // busy, ignored
    add_typed(ModeStop, '0, status(0, 0, 0, 0, 1));
    add_typed(ModePlay, NoPatternCode, status(800, 128, 1, 1, 0));
    add_word(ModeTick, '0, 149);
    add_typed(ModeTick, '0, status(0, 0, 0, 0, 1));
    add_typed(ModePlay, 5'd1, status(600, 128, 1, 1, 0));
    add_word(ModeTick, '0, 59);
    add_typed(ModeTick, '0, status(0, 0, 0, 1, 0));
    add_typed(ModeNone, '1, status(0, 0, 0, 1, 0));
    add_volume(8'd255);
    add_word(ModeTick, '1, 29);
    add_typed(ModeTick, '0, status(900, 255, 1, 1, 0));
    add_volume(8'd0);
    add_typed(ModeTick, '0, status(900, 0, 1, 1, 0));
    add_typed(ModeStop, '0, status(0, 0, 0, 0, 1));
    add_volume(VolumeReset);
    add_typed(ModePlay, 5'd5, status(1800, 128, 1, 1, 0));
    add_word(ModeTick, '0, 49);
    add_typed(ModeTick, '0, status(0, 0, 0, 1, 0));
    add_typed(ModeStop, '0, status(0, 0, 0, 0, 1));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowVolume) begin
        drain();
        write_volume(plan[i].vol);
      end else begin
        repeat (plan[i].reps) push_word(plan[i].mode, plan[i].code, plan[i].typed,
                                        plan[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 51 : 0;
      snk_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 30 : 0;
      drain();
      write_volume(VolW'($urandom_range(255)));
      random_session(60);
    end

    drain();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d request words, checked %0d status words.", words_sent, words_seen);
    $display("Patterns ended or stopped: %0d; volume settings: %0d.", pat_ended, vol_writes);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/tps_pkg.sv
sv/tps_in_if.sv
sv/tps_out_if.sv
sv/tps_seq_core.sv
sv/tone_pattern_sequencer.sv
bench/tone_pattern_sequencer_tb.sv
